// ----- rtl/psrch_pkg.sv -----
// ----------------------------------------------------------------------------
// psrch_pkg
// Shared types and codes for the partitioned sorted search block.
// ----------------------------------------------------------------------------
package psrch_pkg;

    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 8;
    localparam int CFG_W    = 5;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FOUND         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_DIVISIBLE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL          = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED       = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/psrch_div.sv -----
// ----------------------------------------------------------------------------
// psrch_div
// Restoring divider, one quotient bit per cycle, for element count / parts.
// ----------------------------------------------------------------------------
module psrch_div #(
    parameter int N_W = 9,
    parameter int D_W = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [N_W-1:0]        dividend,
    input  logic [D_W-1:0]        divisor,
    output psrch_pkg::div_stat_t  stat,
    output logic [N_W-1:0]        quotient,
    output logic [D_W-1:0]        remainder
);
    import psrch_pkg::*;

    localparam int STEP_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic [N_W-1:0]    q_reg, q_next;
    logic [D_W-1:0]    r_reg, r_next;
    logic [D_W-1:0]    d_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [D_W:0]      trial;
    logic              qbit;

    always_comb begin
        trial  = {r_reg, q_reg[N_W-1]};
        qbit   = (trial >= {1'b0, d_reg});
        r_next = qbit ? D_W'(trial - {1'b0, d_reg}) : trial[D_W-1:0];
        q_next = N_W'({q_reg, qbit});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(N_W - 1);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ----- rtl/partitioned_sorted_search.sv -----
// ----------------------------------------------------------------------------
// partitioned_sorted_search
// Sorted store of signed values with partitioned binary search.
// ----------------------------------------------------------------------------
// One item at a time. A load walks down from the top of the store, moving each
// entry greater than the new value up one place, then writes the value into the
// gap. A search first divides the element count by the partition count, then
// probes each partition in turn, a read state and a compare state per probe,
// until the lowest partition hits. Clear and unused modes go straight to the
// output state. The store has a single read port, shared by probes and shifts.
// No item is taken while one is at work; a finished result waits in the output
// register without stalling the next accept.
module partitioned_sorted_search #(
    parameter int MAX_ELEMENTS = 256,
    parameter int MAX_PARTS    = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psrch_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  logic [psrch_pkg::MODE_W-1:0]   s_tuser,   // [1:0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psrch_pkg::POS_W-1:0]    m_tdata,   // [7:0] position
    output logic [psrch_pkg::STATUS_W-1:0] m_tuser,   // [2:0] status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [psrch_pkg::CFG_W-1:0]    cfg_data
);
    import psrch_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_DIV     = 3'd3;
    localparam logic [2:0] S_PROBE   = 3'd4;
    localparam logic [2:0] S_CMP     = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [VALUE_W-1:0] mem [MAX_ELEMENTS];

    logic [2:0]          state_reg;
    logic [CFG_W-1:0]    cfg_reg;
    logic [CFG_W-1:0]    parts;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    base_reg;
    logic [CNT_W-1:0]    size_reg;
    logic [CFG_W-1:0]    part_reg;
    logic signed [CNT_W:0] low_reg;
    logic signed [CNT_W:0] high_reg;
    logic [CNT_W-1:0]    mid_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [POS_W-1:0]    res_pos_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [POS_W-1:0]    m_pos_reg;

    logic                  accept;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [VALUE_W-1:0]    mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [VALUE_W-1:0]    rd_data_reg;
    logic signed [CNT_W+1:0] lh_sum;
    logic [CNT_W-1:0]      mid;
    logic [CNT_W-1:0]      hit_idx;
    logic                  div_start;
    div_stat_t             div_stat;
    logic [CNT_W-1:0]      div_q;
    logic [CFG_W-1:0]      div_r;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign div_start = accept && (s_tuser == MODE_SEARCH);

    always_comb begin
        if (cfg_reg == '0) begin
            parts = CFG_W'(1);
        end else if (int'(cfg_reg) > MAX_PARTS) begin
            parts = CFG_W'(MAX_PARTS);
        end else begin
            parts = cfg_reg;
        end
    end

    assign lh_sum  = {low_reg[CNT_W], low_reg} + {high_reg[CNT_W], high_reg};
    assign mid     = lh_sum[CNT_W:1];
    assign hit_idx = base_reg + mid_reg;

    psrch_div #(
        .N_W (CNT_W),
        .D_W (CFG_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (count_reg),
        .divisor   (parts),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[ADDR_W-1:0];
        mem_wdata = value_reg;
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(idx_reg - 1'b1);
        if (state_reg == S_INS_RD && idx_reg == '0) begin
            mem_we = 1'b1;
        end
        if (state_reg == S_INS_RD && idx_reg != '0) begin
            mem_re = 1'b1;
        end
        if (state_reg == S_INS_CMP) begin
            mem_we = 1'b1;
            if ($signed(rd_data_reg) > $signed(value_reg)) begin
                mem_wdata = rd_data_reg;
            end
        end
        if (state_reg == S_PROBE && low_reg <= high_reg) begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(base_reg + mid);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        value_reg   <= s_tdata;
                        res_pos_reg <= '0;
                        case (s_tuser)
                            MODE_LOAD: begin
                                if (int'(count_reg) >= MAX_ELEMENTS) begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_OUT;
                                end else begin
                                    idx_reg   <= count_reg;
                                    state_reg <= S_INS_RD;
                                end
                            end
                            MODE_SEARCH: begin
                                state_reg <= S_DIV;
                            end
                            MODE_CLEAR: begin
                                count_reg      <= '0;
                                res_status_reg <= ST_CLEARED;
                                state_reg      <= S_OUT;
                            end
                            default: begin
                                res_status_reg <= ST_NOT_FOUND;
                                state_reg      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (idx_reg == '0) begin
                        count_reg      <= count_reg + 1'b1;
                        res_status_reg <= ST_LOADED;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if ($signed(rd_data_reg) > $signed(value_reg)) begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_INS_RD;
                    end else begin
                        count_reg      <= count_reg + 1'b1;
                        res_status_reg <= ST_LOADED;
                        state_reg      <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        size_reg <= div_q;
                        base_reg <= '0;
                        part_reg <= '0;
                        low_reg  <= '0;
                        high_reg <= $signed({1'b0, div_q} - 1'b1);
                        if (div_r != '0) begin
                            res_status_reg <= ST_NOT_DIVISIBLE;
                            state_reg      <= S_OUT;
                        end else if (div_q == '0) begin
                            res_status_reg <= ST_NOT_FOUND;
                            state_reg      <= S_OUT;
                        end else begin
                            state_reg <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    if (low_reg > high_reg) begin
                        if (part_reg == parts - 1'b1) begin
                            res_status_reg <= ST_NOT_FOUND;
                            state_reg      <= S_OUT;
                        end else begin
                            part_reg <= part_reg + 1'b1;
                            base_reg <= base_reg + size_reg;
                            low_reg  <= '0;
                            high_reg <= $signed({1'b0, size_reg} - 1'b1);
                        end
                    end else begin
                        mid_reg   <= mid;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (rd_data_reg == value_reg) begin
                        res_status_reg <= ST_FOUND;
                        res_pos_reg    <= POS_W'(hit_idx);
                        state_reg      <= S_OUT;
                    end else if ($signed(rd_data_reg) < $signed(value_reg)) begin
                        low_reg   <= $signed({1'b0, mid_reg} + 1'b1);
                        state_reg <= S_PROBE;
                    end else begin
                        high_reg  <= $signed({1'b0, mid_reg} - 1'b1);
                        state_reg <= S_PROBE;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_status_reg <= res_status_reg;
                        m_pos_reg    <= res_pos_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pos_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ----- rtl/psrch_chk.sv -----
// ----------------------------------------------------------------------------
// psrch_chk
// Port-level checks for the partitioned sorted search block.
// ----------------------------------------------------------------------------
module psrch_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [psrch_pkg::POS_W-1:0]    m_tdata,
    input logic [psrch_pkg::STATUS_W-1:0] m_tuser
);
    import psrch_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held across an accepted item");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_FOUND) |-> m_tdata == '0)
        else $error("position set without a hit");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_CLEARED)
        else $error("status code out of range");

endmodule

bind partitioned_sorted_search psrch_chk u_psrch_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
